FILE: src/sms_pkg.sv
// Shared types and constants for the serial mailbox slave.
// Holds the item structs, command and opcode codes, and framing phase codes.
// No dependencies.
package sms_pkg;

    // Commands carried by an input item.
    localparam logic [1:0] CMD_PIN_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_WORD_WRITE = 2'd1;
    localparam logic [1:0] CMD_WORD_READ  = 2'd2;

    // Serial opcodes.
    localparam logic [1:0] OP_WRITE = 2'b01;
    localparam logic [1:0] OP_READ  = 2'b10;

    // Framing phase codes.
    localparam logic [1:0] PHASE_IDLE    = 2'd0;
    localparam logic [1:0] PHASE_ADDRESS = 2'd1;
    localparam logic [1:0] PHASE_WRITE   = 2'd2;
    localparam logic [1:0] PHASE_READ    = 2'd3;

    // Word that requests command execution when written to the status word.
    localparam logic [15:0] REQUEST_WORD = 16'h0055;

    // Reset value of the status word index register.
    localparam logic [4:0] STATUS_INDEX_RESET = 5'd31;

    // Serial address width.
    localparam int SER_ADDR_W = 6;

    typedef struct packed {
        logic [1:0]  cmd;
        logic        chip_select;
        logic        serial_clock;
        logic        data_in;
        logic [4:0]  word_index;
        logic [15:0] word_value;
    } t_in_item;

    typedef struct packed {
        logic        data_out;
        logic        command_request;
        logic [15:0] read_value;
    } t_out_item;

endpackage

FILE: src/serial_mailbox_slave.sv
// Top level of the serial mailbox slave: serial framing, mailbox access and
// output staging. Depends on sms_pkg and sms_mailbox.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) carries one item per
//   pin sample or back-end word access. Every item yields exactly one result
//   item on the output channel (o_out_valid / i_out_ready / o_out_item).
//   The configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes
//   the status word index; it is always ready. The user must see that it is
//   used only while idle; the block does not enforce this.
// Throughput and staging:
//   One item is accepted per cycle unless a stall holds o_in_ready low. A
//   result passes the read stage (registered mailbox read), then the output
//   register. The serial framing state lives in flops and is updated in the
//   accept cycle; a word fetched for a serial read is used straight from the
//   RAM output register, so back-to-back pin samples need no bubble.
// Reset:
//   Synchronous, active low. Framing returns to idle, the data line level to
//   high, the status index to 31, and all mailbox words read as zero through
//   per-word valid bits; no clearing pass is needed.
// Stalls:
//   When the receiver holds i_out_ready low, one result waits in the output
//   register and one more in the read stage; after that o_in_ready drops.
module serial_mailbox_slave
    import sms_pkg::*;
#(
    parameter int MAILBOX_DEPTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [4:0] i_cfg_data
);

    localparam int AW = (MAILBOX_DEPTH > 1) ? $clog2(MAILBOX_DEPTH) : 1;
    localparam logic [SER_ADDR_W-1:0] SLOT_MASK = SER_ADDR_W'(MAILBOX_DEPTH - 1);

    // Framing state.
    logic                  r_sel, n_sel;
    logic                  r_prev_clk, n_prev_clk;
    logic [1:0]            r_phase, n_phase;
    logic [16:0]           r_shift_in, n_shift_in;
    logic [SER_ADDR_W-1:0] r_addr, n_addr;
    logic [15:0]           r_shift_out, n_shift_out;
    logic                  r_so_mem, n_so_mem;
    logic                  r_out_level, n_out_level;
    logic [4:0]            r_status_idx;

    // Read stage and output register.
    logic      r_s1_valid;
    logic      r_s1_level;
    logic      r_s1_req;
    logic      r_s1_rd;
    logic      r_out_valid;
    t_out_item r_out;

    // Memory access for the current item.
    logic                  mem_we, mem_re;
    logic [SER_ADDR_W-1:0] mem_waddr6, mem_raddr6;
    logic [15:0]           mem_wdata, mem_rdata;
    logic                  req, backend_rd;

    logic                  accept, s1_move;
    logic [15:0]           eff_so;
    logic [16:0]           si_next;

    assign s1_move     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_s1_valid || s1_move;
    assign accept      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // Shift-out word: taken from the RAM output while a serial read fetch is fresh.
    assign eff_so = r_so_mem ? mem_rdata : r_shift_out;

    // Pin sample framing and mailbox access decode.
    always_comb begin
        n_sel       = r_sel;
        n_prev_clk  = r_prev_clk;
        n_phase     = r_phase;
        n_shift_in  = r_shift_in;
        n_addr      = r_addr;
        n_shift_out = eff_so;
        n_so_mem    = 1'b0;
        n_out_level = r_out_level;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr6  = '0;
        mem_raddr6  = '0;
        mem_wdata   = i_in_item.word_value;
        req         = 1'b0;
        backend_rd  = 1'b0;
        si_next     = '0;
        unique case (i_in_item.cmd)
            CMD_PIN_SAMPLE: begin
                if (i_in_item.chip_select != r_sel) begin
                    n_sel       = i_in_item.chip_select;
                    n_phase     = PHASE_IDLE;
                    n_shift_in  = '0;
                    n_out_level = 1'b1;
                end
                n_prev_clk = i_in_item.serial_clock;
                if (i_in_item.chip_select && i_in_item.serial_clock && !r_prev_clk) begin
                    si_next = {n_shift_in[15:0], i_in_item.data_in};
                    unique case (n_phase)
                        PHASE_IDLE: begin
                            if (i_in_item.data_in) begin
                                n_shift_in = 17'd1;
                                n_phase    = PHASE_ADDRESS;
                            end
                        end
                        PHASE_READ: begin
                            n_out_level = eff_so[15];
                            n_shift_out = {eff_so[14:0], 1'b0};
                        end
                        PHASE_ADDRESS: begin
                            n_shift_in = si_next;
                            if (si_next[8]) begin
                                n_addr = si_next[5:0];
                                if (si_next[7:6] == OP_READ) begin
                                    mem_re      = 1'b1;
                                    mem_raddr6  = si_next[5:0] & SLOT_MASK;
                                    n_so_mem    = 1'b1;
                                    n_out_level = 1'b0;
                                    n_phase     = PHASE_READ;
                                end else if (si_next[7:6] == OP_WRITE) begin
                                    n_shift_in = 17'd1;
                                    n_phase    = PHASE_WRITE;
                                end else begin
                                    n_phase = PHASE_IDLE;
                                end
                            end
                        end
                        default: begin
                            // Write phase: collect 16 data bits behind the marker.
                            n_shift_in = si_next;
                            if (si_next[16]) begin
                                mem_we     = 1'b1;
                                mem_waddr6 = r_addr & SLOT_MASK;
                                mem_wdata  = si_next[15:0];
                                n_phase    = PHASE_IDLE;
                                req = (r_addr == {1'b0, r_status_idx})
                                      && (si_next[15:0] == REQUEST_WORD);
                            end
                        end
                    endcase
                end
            end
            CMD_WORD_WRITE: begin
                mem_we     = 1'b1;
                mem_waddr6 = {1'b0, i_in_item.word_index} & SLOT_MASK;
            end
            CMD_WORD_READ: begin
                mem_re     = 1'b1;
                mem_raddr6 = {1'b0, i_in_item.word_index} & SLOT_MASK;
                backend_rd = 1'b1;
            end
            default: begin
                // Unused command leaves all state alone.
            end
        endcase
    end

    sms_mailbox #(
        .DEPTH (MAILBOX_DEPTH),
        .AW    (AW)
    ) u_mailbox (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (accept && mem_we),
        .i_waddr (mem_waddr6[AW-1:0]),
        .i_wdata (mem_wdata),
        .i_re    (accept && mem_re),
        .i_raddr (mem_raddr6[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    // Framing state registers, updated once per accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel       <= 1'b0;
            r_prev_clk  <= 1'b0;
            r_phase     <= PHASE_IDLE;
            r_shift_in  <= '0;
            r_addr      <= '0;
            r_shift_out <= '0;
            r_so_mem    <= 1'b0;
            r_out_level <= 1'b1;
        end else if (accept) begin
            r_sel       <= n_sel;
            r_prev_clk  <= n_prev_clk;
            r_phase     <= n_phase;
            r_shift_in  <= n_shift_in;
            r_addr      <= n_addr;
            r_shift_out <= n_shift_out;
            r_so_mem    <= n_so_mem;
            r_out_level <= n_out_level;
        end
    end

    // Status word index register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status_idx <= STATUS_INDEX_RESET;
        end else if (i_cfg_valid) begin
            r_status_idx <= i_cfg_data;
        end
    end

    // Read stage: holds the item while the registered mailbox read completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_level <= n_out_level;
            r_s1_req   <= req;
            r_s1_rd    <= backend_rd;
        end
    end

    // Output register holding the finished result item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out.data_out        <= r_s1_level;
            r_out.command_request <= r_s1_req;
            r_out.read_value      <= r_s1_rd ? mem_rdata : 16'h0000;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

FILE: src/sms_mailbox.sv
// Mailbox word store: synchronous RAM with separate write and read ports and a registered read.
// Per-entry valid bits make never-written words read as zero after reset.
// Depends on nothing outside this file.
module sms_mailbox #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [15:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [15:0]   o_rdata
);

    logic [15:0]      r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [15:0]      r_q;
    logic             r_q_vld;

    // Storage array, write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    // Valid bits: cleared at reset, set by the first write of each word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_q_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_q_vld <= r_vld[i_raddr];
            end
        end
    end

    // A word that was never written reads as zero.
    assign o_rdata = r_q_vld ? r_q : 16'h0000;

endmodule

FILE: bench/tb_serial_mailbox_slave.sv
// Self-checking testbench for serial_mailbox_slave: serial frames, back-end word
// access and status-index writes, checked against an in-bench behavioral image.
// Depends on sms_pkg and the serial_mailbox_slave RTL only.
`timescale 1ns / 1ps

module tb_serial_mailbox_slave;
    import sms_pkg::*;

    localparam int MBOX_DEPTH   = 32;
    localparam int MBOX_AW      = $clog2(MBOX_DEPTH);
    localparam int LIMIT_CYCLES = 400000;
    localparam int PRINT_CAP    = 100;

    // Codes the package does not name.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [1:0] OP_NONE    = 2'b00;
    localparam logic [1:0] OP_SPARE   = 2'b11;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [4:0] cfg_data = '0;

    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int backend_mix_pct = 0;
    int item_count      = 0;
    int mismatch_count  = 0;
    int cycle_count     = 0;

    // Behavioral image of the slave.
    logic [15:0] mbox_img [MBOX_DEPTH];
    logic        sel_img;
    logic        prev_clk_img;
    logic [1:0]  phase_img;
    logic [16:0] shift_img;
    logic [5:0]  addr_img;
    logic [15:0] word_out_img;
    logic        line_img;
    logic [4:0]  status_idx_img;

    t_out_item responses_due [$];

    serial_mailbox_slave #(
        .MAILBOX_DEPTH(MBOX_DEPTH)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // Run limit in case the block hangs.
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_serial_mailbox_slave NOT OK");
        $finish;
    end

    task automatic note_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
        if (mismatch_count < PRINT_CAP)
            $display("mismatch: %s got %h expected %h at cycle %0d", what, got, want,
                     cycle_count);
        mismatch_count++;
    endtask

    function automatic void reset_image();
        for (int i = 0; i < MBOX_DEPTH; i++)
            mbox_img[i] = '0;
        sel_img        = 1'b0;
        prev_clk_img   = 1'b0;
        phase_img      = PHASE_IDLE;
        shift_img      = '0;
        addr_img       = '0;
        word_out_img   = '0;
        line_img       = 1'b1;
        status_idx_img = STATUS_INDEX_RESET;
    endfunction

    // One pin sample; returns 1 when a serial write asks for command execution.
    function automatic logic serial_sample(input logic sel, input logic sclk,
                                           input logic din);
        logic [15:0] value;
        logic [1:0]  opcode;
        if (sel != sel_img) begin
            sel_img   = sel;
            phase_img = PHASE_IDLE;
            shift_img = '0;
            line_img  = 1'b1;
        end
        if (!sel || !sclk || prev_clk_img) begin
            prev_clk_img = sclk;
            return 1'b0;
        end
        prev_clk_img = sclk;

        if (phase_img == PHASE_IDLE) begin
            if (din) begin
                shift_img = 17'd1;
                phase_img = PHASE_ADDRESS;
            end
            return 1'b0;
        end
        if (phase_img == PHASE_READ) begin
            line_img     = word_out_img[15];
            word_out_img = word_out_img << 1;
            return 1'b0;
        end

        shift_img = {shift_img[15:0], din};
        if (phase_img == PHASE_ADDRESS && shift_img[8]) begin
            opcode   = shift_img[7:6];
            addr_img = shift_img[5:0];
            if (opcode == OP_READ) begin
                word_out_img = mbox_img[MBOX_AW'(addr_img & 6'(MBOX_DEPTH - 1))];
                line_img     = 1'b0;
                phase_img    = PHASE_READ;
            end else if (opcode == OP_WRITE) begin
                shift_img = 17'd1;
                phase_img = PHASE_WRITE;
            end else begin
                phase_img = PHASE_IDLE;
            end
        end else if (phase_img == PHASE_WRITE && shift_img[16]) begin
            value = shift_img[15:0];
            mbox_img[MBOX_AW'(addr_img & 6'(MBOX_DEPTH - 1))] = value;
            phase_img = PHASE_IDLE;
            // The full six-bit address must match, not the masked slot.
            if (addr_img == {1'b0, status_idx_img} && value == REQUEST_WORD)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Result of one accepted item, updating the image.
    function automatic t_out_item slave_response(input t_in_item it);
        t_out_item r;
        r = '0;
        case (it.cmd)
            CMD_PIN_SAMPLE: begin
                r.command_request = serial_sample(it.chip_select, it.serial_clock,
                                                  it.data_in);
            end
            CMD_WORD_WRITE: begin
                mbox_img[it.word_index & 5'(MBOX_DEPTH - 1)] = it.word_value;
            end
            CMD_WORD_READ: begin
                r.read_value = mbox_img[it.word_index & 5'(MBOX_DEPTH - 1)];
            end
            default: ;
        endcase
        r.data_out = line_img;
        return r;
    endfunction

    // Result checker.
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (responses_due.size() == 0) begin
                note_mismatch("unexpected result, read_value", out_item.read_value, '0);
            end else begin
                want = responses_due.pop_front();
                if (out_item.data_out !== want.data_out)
                    note_mismatch("data_out", 16'(out_item.data_out), 16'(want.data_out));
                if (out_item.command_request !== want.command_request)
                    note_mismatch("command_request", 16'(out_item.command_request),
                                  16'(want.command_request));
                if (out_item.read_value !== want.read_value)
                    note_mismatch("read_value", out_item.read_value, want.read_value);
            end
        end
    end

    // Receiver stalls.
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Valid stays high between back-to-back items; it drops only for idle cycles.
    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        responses_due.push_back(slave_response(it));
        item_count++;
    endtask

    // Pauses the sender until every expected result has come, then lets the
    // pipeline settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (responses_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_status_index(input logic [4:0] idx);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= idx;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        status_idx_img = idx;
        @(posedge clk);
    endtask

    function automatic t_in_item word_item(input logic [1:0] cmd, input logic [4:0] idx,
                                           input logic [15:0] val);
        t_in_item it;
        it              = '0;
        it.cmd          = cmd;
        it.chip_select  = 1'($urandom_range(1));
        it.serial_clock = 1'($urandom_range(1));
        it.data_in      = 1'($urandom_range(1));
        it.word_index   = idx;
        it.word_value   = val;
        return it;
    endfunction

    function automatic t_in_item random_backend();
        logic [1:0] cmd;
        case ($urandom_range(2))
            0:       cmd = CMD_WORD_WRITE;
            1:       cmd = CMD_WORD_READ;
            default: cmd = CMD_UNUSED;
        endcase
        return word_item(cmd, 5'($urandom_range(31)), 16'($urandom));
    endfunction

    // Pin sample, sometimes preceded by a back-end access.
    task automatic pin(input logic sel, input logic sclk, input logic din);
        t_in_item it;
        if ($urandom_range(99) < backend_mix_pct)
            send_item(random_backend());
        it              = '0;
        it.cmd          = CMD_PIN_SAMPLE;
        it.chip_select  = sel;
        it.serial_clock = sclk;
        it.data_in      = din;
        it.word_index   = 5'($urandom_range(31));
        it.word_value   = 16'($urandom);
        send_item(it);
    endtask

    // One serial bit: clock low, then the rising edge, now and then held high.
    task automatic clock_bit(input logic din);
        pin(1'b1, 1'b0, din);
        pin(1'b1, 1'b1, din);
        if ($urandom_range(7) == 0)
            pin(1'b1, 1'b1, 1'($urandom_range(1)));
    endtask

    task automatic shift_bits(input logic [31:0] bits, input int n);
        for (int i = n - 1; i >= 0; i--)
            clock_bit(bits[i]);
    endtask

    task automatic clock_out(input int n);
        repeat (n) clock_bit(1'($urandom_range(1)));
    endtask

    // Deselect and reselect so that the framing starts from idle.
    task automatic open_frame();
        pin(1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)));
        pin(1'b1, 1'b0, 1'($urandom_range(1)));
    endtask

    task automatic write_frame(input logic [5:0] addr, input logic [15:0] value);
        shift_bits(32'({1'b1, OP_WRITE, addr, value}), 25);
    endtask

    task automatic read_frame(input logic [5:0] addr, input int edges);
        shift_bits(32'({1'b1, OP_READ, addr}), 9);
        clock_out(edges);
    endtask

    // Back-end word access at the index and value extremes, plus the unused command.
    task automatic test_backend_words();
        send_item(word_item(CMD_WORD_READ, 5'd17, 16'h1234));
        send_item(word_item(CMD_WORD_WRITE, 5'd0, 16'hFFFF));
        send_item(word_item(CMD_WORD_WRITE, 5'd31, 16'h0000));
        send_item(word_item(CMD_WORD_WRITE, 5'd21, 16'hA5C3));
        send_item(word_item(CMD_UNUSED, 5'd21, 16'h0000));
        send_item(word_item(CMD_WORD_READ, 5'd0, 16'h0000));
        send_item(word_item(CMD_WORD_READ, 5'd31, 16'hFFFF));
        send_item(word_item(CMD_WORD_READ, 5'd21, 16'h0000));
    endtask

    // Serial write and read, the request word at both status addresses, and
    // reading past the end of the word.
    task automatic test_serial_access();
        open_frame();
        write_frame(6'd0, 16'hFFFF);
        write_frame(6'd31, REQUEST_WORD);
        write_frame(6'd63, REQUEST_WORD);
        send_item(word_item(CMD_WORD_READ, 5'd31, 16'h0000));
        send_item(word_item(CMD_WORD_WRITE, 5'd5, 16'h8001));
        open_frame();
        read_frame(6'd37, 20);
        open_frame();
        read_frame(6'd0, 16);
    endtask

    // Unknown opcodes, a frame cut by chip select, and back-end items inside frames.
    task automatic test_framing_breaks();
        open_frame();
        shift_bits(32'({1'b1, OP_NONE, 6'd12}), 9);
        shift_bits(32'({1'b1, OP_SPARE, 6'd12}), 9);
        write_frame(6'd12, 16'h0F0F);
        open_frame();
        shift_bits(32'({1'b1, OP_WRITE, 6'd12, 8'hAA}), 17);
        open_frame();
        backend_mix_pct = 50;
        write_frame(6'd44, 16'h7E81);
        read_frame(6'd44, 17);
        backend_mix_pct = 0;
        open_frame();
    endtask

    // Request detection follows the status index register.
    task automatic test_status_index();
        logic [4:0] idx;
        for (int k = 0; k < 3; k++) begin
            idx = (k == 0) ? 5'd0 : (k == 1) ? 5'($urandom_range(1, 30)) : 5'd31;
            set_status_index(idx);
            open_frame();
            write_frame({1'b0, idx}, REQUEST_WORD);
            write_frame({1'b1, idx}, REQUEST_WORD);
            write_frame({1'b0, idx}, 16'h0054);
        end
    endtask

    task automatic random_frame();
        int          pick;
        int          cut;
        logic [5:0]  addr;
        logic [15:0] value;
        logic [24:0] frame;
        pick  = $urandom_range(99);
        addr  = 6'($urandom_range(63));
        if ($urandom_range(3) == 0)
            addr = {1'($urandom_range(1)), status_idx_img};
        value = 16'($urandom);
        if ($urandom_range(2) == 0)
            value = REQUEST_WORD;
        open_frame();
        // A few idle edges before the start bit.
        repeat ($urandom_range(2)) clock_bit(1'b0);
        if (pick < 40) begin
            write_frame(addr, value);
            if ($urandom_range(1))
                write_frame(6'($urandom_range(63)), 16'($urandom));
        end else if (pick < 70) begin
            read_frame(addr, $urandom_range(16, 20));
        end else if (pick < 82) begin
            frame = {1'b1, ($urandom_range(1) ? OP_WRITE : OP_READ), addr, value};
            cut   = $urandom_range(1, 24);
            shift_bits(32'(frame >> (25 - cut)), cut);
        end else if (pick < 90) begin
            shift_bits(32'({1'b1, ($urandom_range(1) ? OP_SPARE : OP_NONE), addr, value}),
                       25);
        end else begin
            repeat ($urandom_range(4, 16)) begin
                if ($urandom_range(3) == 0)
                    send_item(random_backend());
                else
                    pin(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
            end
        end
    endtask

    task automatic test_random_traffic(input int count, input int s_idle, input int r_idle);
        int start;
        send_idle_pct   = s_idle;
        recv_idle_pct   = r_idle;
        backend_mix_pct = 10;
        start           = item_count;
        while (item_count - start < count)
            random_frame();
        backend_mix_pct = 0;
        wait_idle();
    endtask

    initial begin
        reset_image();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_backend_words();
        test_serial_access();
        test_framing_breaks();
        test_status_index();

        set_status_index(5'd0);
        test_random_traffic(210, 32, 56);
        set_status_index(5'($urandom_range(31)));
        test_random_traffic(210, 56, 32);
        set_status_index(5'd31);
        test_random_traffic(210, 0, 0);

        // Catch any stray result after the last expected one.
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_serial_mailbox_slave OK");
        else
            $display("tb_serial_mailbox_slave NOT OK");
        $finish;
    end

endmodule

FILE: filelist.f
src/sms_pkg.sv
src/sms_mailbox.sv
src/serial_mailbox_slave.sv
bench/tb_serial_mailbox_slave.sv
